// ===== hw/rtl/fcpa_pkg.sv =====
// Shared types, sizes and codes of the fixed chunk pool allocator.
`default_nettype none

package fcpa_pkg;

	localparam int MAX_CHUNKS = 256;
	localparam int ADDR_BITS  = 48;
	localparam int IDX_BITS   = $clog2(MAX_CHUNKS);
	localparam int LINK_BITS  = $clog2(MAX_CHUNKS + 1);

	localparam int SHIFT_BITS = 5;
	localparam int COUNT_BITS = 9;
	localparam int CFG_BITS   = ADDR_BITS;
	localparam int INDEX_BITS = 2;

	localparam int IN_BITS  = ((2 + ADDR_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = ((ADDR_BITS + 2 + 7) / 8) * 8;

	localparam logic [1:0] OP_ALLOC    = 2'd0;
	localparam logic [1:0] OP_FREE     = 2'd1;
	localparam logic [1:0] OP_FREE_ALL = 2'd2;
	localparam logic [1:0] OP_RESERVED = 2'd3;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_RANGE = 2'd2;
	localparam logic [1:0] STATUS_NULL  = 2'd3;

	localparam logic [INDEX_BITS-1:0] REG_POOL_BASE   = 2'd0;
	localparam logic [INDEX_BITS-1:0] REG_CHUNK_SHIFT = 2'd1;
	localparam logic [INDEX_BITS-1:0] REG_CHUNK_COUNT = 2'd2;

	localparam logic [COUNT_BITS-1:0] CHUNK_COUNT_RESET = 9'd256;
	localparam logic [SHIFT_BITS-1:0] CHUNK_SHIFT_RESET = 5'd6;

	typedef enum logic [1:0] {
		ST_FILL,
		ST_IDLE,
		ST_CALC,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fcpa_ram.sv =====
// Generic single-port RAM with registered read data.
`default_nettype none

module fcpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/fixed_chunk_pool_allocator.sv =====
// Top level of the fixed chunk pool allocator: LIFO free list over a link RAM.
//
// Requests enter on s_axis (op, address); one response per request leaves on
// m_axis (chunk_address, status). Allocate pops the free-list head, free pushes
// the chunk that holds the address, free all rebuilds the list so chunks are
// handed out from the highest index down. The user must write registers through
// cfg_we / cfg_index / cfg_data only while no request is in flight;
// the block does not enforce this.
//
// A request passes through the CALC state (link RAM read, or address subtract
// and limit shift) and the DONE state (check and write back). The next request
// is taken only once the last response is in the output register. Free all
// then writes the link RAM once per chunk, at most 256, before the next request.
//
// After reset the block rebuilds the full list for 256 chunks, one RAM write
// a cycle, and takes no request until the list is built. A response waits in
// the output register while m_axis_tready is low; a new request is still
// captured, but its response is held back until the output register is free.
`default_nettype none

module fixed_chunk_pool_allocator (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// fields from bit 0: op[1:0], address[49:2], zero padding
	input  wire logic [fcpa_pkg::IN_BITS-1:0]       s_axis_tdata,
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	// fields from bit 0: chunk_address[47:0], status[49:48], zero padding
	output logic      [fcpa_pkg::OUT_BITS-1:0]      m_axis_tdata,
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	input  wire logic                               cfg_we,
	input  wire logic [fcpa_pkg::INDEX_BITS-1:0]    cfg_index,
	input  wire logic [fcpa_pkg::CFG_BITS-1:0]      cfg_data
);

	localparam int AW = fcpa_pkg::ADDR_BITS;
	localparam int IW = fcpa_pkg::IDX_BITS;
	localparam int LW = fcpa_pkg::LINK_BITS;

	fcpa_pkg::state_t state_q, state_d;

	logic [AW-1:0]                   pool_base_q;
	logic [fcpa_pkg::SHIFT_BITS-1:0] chunk_shift_q;
	logic [fcpa_pkg::COUNT_BITS-1:0] chunk_count_q;

	logic [LW-1:0] free_head_q;
	logic [LW-1:0] fill_cnt_q;
	logic [LW-1:0] fill_n_q;

	logic [1:0]    op_q;
	logic [AW-1:0] addr_q;

	logic [AW:0]   diff_s1;
	logic [AW-1:0] limit_s1;
	logic [AW-1:0] alloc_addr_s1;

	logic          out_valid_q;
	logic [AW-1:0] out_addr_q;
	logic [1:0]    out_status_q;

	logic          ram_we;
	logic          ram_re;
	logic [IW-1:0] ram_addr;
	logic [LW-1:0] ram_wdata;
	logic [LW-1:0] ram_rdata;

	logic [LW-1:0] live_w;
	logic [LW-1:0] head_idx_w;
	logic [AW-1:0] free_off_w;
	logic [IW-1:0] free_idx_w;
	logic          free_ok_w;
	logic          slot_free_w;

	fcpa_ram #(
		.WIDTH (LW),
		.DEPTH (fcpa_pkg::MAX_CHUNKS)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign live_w = (32'(chunk_count_q) > fcpa_pkg::MAX_CHUNKS) ?
		LW'(fcpa_pkg::MAX_CHUNKS) : LW'(chunk_count_q);
	assign head_idx_w  = free_head_q - LW'(1);
	assign free_off_w  = diff_s1[AW-1:0] >> chunk_shift_q;
	assign free_idx_w  = free_off_w[IW-1:0];
	assign free_ok_w   = !diff_s1[AW] && (diff_s1[AW-1:0] < limit_s1);
	assign slot_free_w = !out_valid_q || m_axis_tready;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(fcpa_pkg::OUT_BITS - AW - 2)'(0), out_status_q, out_addr_q};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			fcpa_pkg::ST_FILL: begin
				if (fill_cnt_q == fill_n_q - LW'(1)) begin
					state_d = fcpa_pkg::ST_IDLE;
				end
			end
			fcpa_pkg::ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = fcpa_pkg::ST_CALC;
				end
			end
			fcpa_pkg::ST_CALC: begin
				state_d = fcpa_pkg::ST_DONE;
			end
			fcpa_pkg::ST_DONE: begin
				if (slot_free_w) begin
					if (op_q == fcpa_pkg::OP_FREE_ALL && live_w != '0) begin
						state_d = fcpa_pkg::ST_FILL;
					end else begin
						state_d = fcpa_pkg::ST_IDLE;
					end
				end
			end
			default: state_d = fcpa_pkg::ST_IDLE;
		endcase
	end

	// RAM port and handshake
	always_comb begin
		s_axis_tready = 1'b0;
		ram_we        = 1'b0;
		ram_re        = 1'b0;
		ram_addr      = '0;
		ram_wdata     = '0;
		case (state_q)
			fcpa_pkg::ST_FILL: begin
				ram_we    = 1'b1;
				ram_addr  = fill_cnt_q[IW-1:0];
				ram_wdata = fill_cnt_q;
			end
			fcpa_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
			end
			fcpa_pkg::ST_CALC: begin
				if (op_q == fcpa_pkg::OP_ALLOC && free_head_q != '0) begin
					ram_re   = 1'b1;
					ram_addr = head_idx_w[IW-1:0];
				end
			end
			fcpa_pkg::ST_DONE: begin
				if (slot_free_w && op_q == fcpa_pkg::OP_FREE && addr_q != '0 && free_ok_w) begin
					ram_we    = 1'b1;
					ram_addr  = free_idx_w;
					ram_wdata = free_head_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q   <= '0;
			chunk_shift_q <= fcpa_pkg::CHUNK_SHIFT_RESET;
			chunk_count_q <= fcpa_pkg::CHUNK_COUNT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				fcpa_pkg::REG_POOL_BASE:   pool_base_q   <= cfg_data[AW-1:0];
				fcpa_pkg::REG_CHUNK_SHIFT: chunk_shift_q <= cfg_data[fcpa_pkg::SHIFT_BITS-1:0];
				fcpa_pkg::REG_CHUNK_COUNT: chunk_count_q <= cfg_data[fcpa_pkg::COUNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fcpa_pkg::ST_FILL;
			free_head_q <= '0;
			fill_cnt_q  <= '0;
			fill_n_q    <= LW'(fcpa_pkg::MAX_CHUNKS);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				fcpa_pkg::ST_FILL: begin
					fill_cnt_q <= fill_cnt_q + LW'(1);
					if (fill_cnt_q == fill_n_q - LW'(1)) begin
						free_head_q <= fill_n_q;
					end
				end
				fcpa_pkg::ST_DONE: begin
					if (slot_free_w) begin
						out_valid_q <= 1'b1;
						case (op_q)
							fcpa_pkg::OP_ALLOC: begin
								if (free_head_q != '0) begin
									free_head_q <= ram_rdata;
								end
							end
							fcpa_pkg::OP_FREE: begin
								if (addr_q != '0 && free_ok_w) begin
									free_head_q <= LW'(free_idx_w) + LW'(1);
								end
							end
							fcpa_pkg::OP_FREE_ALL: begin
								// empty list now; the fill pass sets the head at its end
								free_head_q <= '0;
								fill_cnt_q  <= '0;
								fill_n_q    <= live_w;
							end
							default: ;
						endcase
					end
				end
				default: ;
			endcase
		end
	end

	// request capture, address datapath and response payload
	always_ff @(posedge clk) begin
		if (state_q == fcpa_pkg::ST_IDLE && s_axis_tvalid) begin
			op_q   <= s_axis_tdata[1:0];
			addr_q <= s_axis_tdata[AW+1:2];
		end
		if (state_q == fcpa_pkg::ST_CALC) begin
			diff_s1       <= {1'b0, addr_q} - {1'b0, pool_base_q};
			limit_s1      <= AW'(live_w) << chunk_shift_q;
			alloc_addr_s1 <= pool_base_q + (AW'(head_idx_w[IW-1:0]) << chunk_shift_q);
		end
		if (state_q == fcpa_pkg::ST_DONE && slot_free_w) begin
			out_addr_q   <= '0;
			out_status_q <= fcpa_pkg::STATUS_OK;
			case (op_q)
				fcpa_pkg::OP_ALLOC: begin
					if (free_head_q == '0) begin
						out_status_q <= fcpa_pkg::STATUS_EMPTY;
					end else begin
						out_addr_q <= alloc_addr_s1;
					end
				end
				fcpa_pkg::OP_FREE: begin
					if (addr_q == '0) begin
						out_status_q <= fcpa_pkg::STATUS_NULL;
					end else if (!free_ok_w) begin
						out_status_q <= fcpa_pkg::STATUS_RANGE;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire
